[src/srpc_pkg.sv]
// ----------------------------------------------------------------------------
// srpc_pkg
// Shared types and constants for the servo reply packet checker.
// ----------------------------------------------------------------------------
package srpc_pkg;

  localparam int MAX_REPLY_LENGTH  = 32;
  localparam int MIN_REPLY_LENGTH  = 9;
  localparam int TICK_COUNTER_BITS = 16;
  localparam int LEN_W             = 6;
  localparam int CFG_W             = 16;
  localparam int CAP_SLOTS         = 11;
  localparam int FLAG_OFFSET       = 3;
  localparam int DATA_BASE         = 6;

  localparam logic [LEN_W-1:0]             RESET_REPLY_LENGTH  = LEN_W'(26);
  localparam logic [TICK_COUNTER_BITS-1:0] RESET_TIMEOUT_LIMIT = TICK_COUNTER_BITS'(400);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CSUM    = 2'd2,
    ST_FLAGS   = 2'd3
  } status_t;

  typedef enum logic {
    REG_REPLY_LENGTH  = 1'b0,
    REG_TIMEOUT_LIMIT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  servo_flags;
    logic [7:0]  first_data_byte;
    logic [15:0] angle;
    logic [15:0] move_time;
    logic [15:0] speed;
    logic [15:0] load;
    logic [15:0] temperature;
  } result_t;

endpackage

[src/srpc_rx.sv]
// ----------------------------------------------------------------------------
// srpc_rx
// Receive state, checksum, byte capture and tick counting; forms one result
// word per completed or timed-out packet.
// ----------------------------------------------------------------------------
module srpc_rx (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     accept,
  input  logic [1:0]               op,
  input  logic [7:0]               rx_byte,
  output logic                     res_valid,
  output srpc_pkg::result_t        res
);
  import srpc_pkg::*;

  logic [LEN_W-1:0]             reply_length;
  logic [TICK_COUNTER_BITS-1:0] timeout_limit;

  logic                         armed, armed_next;
  logic [LEN_W-1:0]             byte_count, byte_count_next;
  logic [7:0]                   xor_sum, xor_sum_next;
  logic [7:0]                   cap [CAP_SLOTS];
  logic [7:0]                   cap_next [CAP_SLOTS];
  logic [7:0]                   cap_masked [CAP_SLOTS];
  logic [TICK_COUNTER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [LEN_W-1:0]             eff_len;

  // effective length, clamped to the supported range
  always_comb begin
    if (reply_length < LEN_W'(MIN_REPLY_LENGTH)) begin
      eff_len = LEN_W'(MIN_REPLY_LENGTH);
    end else if (reply_length > LEN_W'(MAX_REPLY_LENGTH)) begin
      eff_len = LEN_W'(MAX_REPLY_LENGTH);
    end else begin
      eff_len = reply_length;
    end
  end

  always_comb begin
    armed_next         = armed;
    byte_count_next    = byte_count;
    xor_sum_next       = xor_sum;
    elapsed_ticks_next = elapsed_ticks;
    res_valid          = 1'b0;
    res                = '0;
    for (int i = 0; i < CAP_SLOTS; i++) begin
      cap_next[i] = cap[i];
    end

    if (accept) begin
      case (op)
        OP_START: begin
          armed_next         = 1'b1;
          byte_count_next    = '0;
          xor_sum_next       = '0;
          elapsed_ticks_next = '0;
          for (int i = 0; i < CAP_SLOTS; i++) begin
            cap_next[i] = '0;
          end
        end
        OP_TICK: begin
          if (armed) begin
            if (elapsed_ticks != '1) begin
              elapsed_ticks_next = elapsed_ticks + 1'b1;
            end
            if (elapsed_ticks_next > timeout_limit) begin
              armed_next = 1'b0;
              res_valid  = 1'b1;
              res.status = ST_TIMEOUT;
            end
          end
        end
        OP_BYTE: begin
          if (armed) begin
            if (byte_count == LEN_W'(FLAG_OFFSET)) begin
              cap_next[0] = rx_byte;
            end
            for (int i = 1; i < CAP_SLOTS; i++) begin
              if (byte_count == LEN_W'(i + DATA_BASE)) begin
                cap_next[i] = rx_byte;
              end
            end
            if (byte_count >= LEN_W'(2)) begin
              xor_sum_next = xor_sum ^ rx_byte;
            end
            byte_count_next = byte_count + 1'b1;
            if (byte_count_next >= eff_len) begin
              armed_next = 1'b0;
              res_valid  = 1'b1;
              if (xor_sum_next != 8'd0) begin
                res.status = ST_CSUM;
              end else begin
                res.servo_flags     = cap_masked[0];
                res.status          = (cap_masked[0] != 8'd0) ? ST_FLAGS : ST_OK;
                res.first_data_byte = cap_masked[1];
                res.angle           = {cap_masked[2], cap_masked[1]};
                res.move_time       = {cap_masked[4], cap_masked[3]};
                res.speed           = {cap_masked[6], cap_masked[5]};
                res.load            = {cap_masked[8], cap_masked[7]};
                res.temperature     = {cap_masked[10], cap_masked[9]};
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // bytes at or beyond the effective length read as zero
  always_comb begin
    cap_masked[0] = (LEN_W'(FLAG_OFFSET) < eff_len) ? cap_next[0] : 8'd0;
    for (int i = 1; i < CAP_SLOTS; i++) begin
      cap_masked[i] = (LEN_W'(i + DATA_BASE) < eff_len) ? cap_next[i] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_length  <= RESET_REPLY_LENGTH;
      timeout_limit <= RESET_TIMEOUT_LIMIT;
      armed         <= 1'b0;
      byte_count    <= '0;
      xor_sum       <= '0;
      elapsed_ticks <= '0;
      for (int i = 0; i < CAP_SLOTS; i++) begin
        cap[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REPLY_LENGTH:  reply_length  <= cfg_data[LEN_W-1:0];
          REG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[TICK_COUNTER_BITS-1:0];
          default: begin
          end
        endcase
      end
      armed         <= armed_next;
      byte_count    <= byte_count_next;
      xor_sum       <= xor_sum_next;
      elapsed_ticks <= elapsed_ticks_next;
      for (int i = 0; i < CAP_SLOTS; i++) begin
        cap[i] <= cap_next[i];
      end
    end
  end

endmodule

[src/srpc_out_buf.sv]
// ----------------------------------------------------------------------------
// srpc_out_buf
// Result register with a skid stage so the receiver keeps taking words
// while a result waits downstream.
// ----------------------------------------------------------------------------
module srpc_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  srpc_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output srpc_pkg::result_t out_data
);
  import srpc_pkg::*;

  logic    main_valid, main_valid_next;
  logic    skid_valid, skid_valid_next;
  result_t main_data, main_data_next;
  result_t skid_data, skid_data_next;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_data_next  = main_data;
    skid_data_next  = skid_data;
    if (main_valid && out_ready) begin
      main_valid_next = skid_valid;
      main_data_next  = skid_data;
      skid_valid_next = 1'b0;
    end
    if (push) begin
      if (!main_valid_next) begin
        main_valid_next = 1'b1;
        main_data_next  = push_data;
      end else begin
        skid_valid_next = 1'b1;
        skid_data_next  = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
    main_data <= main_data_next;
    skid_data <= skid_data_next;
  end

  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

endmodule

[src/servo_reply_packet_checker.sv]
// ----------------------------------------------------------------------------
// servo_reply_packet_checker
// Deframes a servo reply packet, checks its XOR sum and reports the fields.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while in_ready is high. A finished
// result is registered in the result register, or in the skid entry if that
// is full, so input is held off only while two results are waiting
// downstream. Configuration writes take effect at once.
module servo_reply_packet_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  servo_flags,
  output logic [7:0]  first_data_byte,
  output logic [15:0] angle,
  output logic [15:0] move_time,
  output logic [15:0] speed,
  output logic [15:0] load,
  output logic [15:0] temperature
);
  import srpc_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign accept = in_valid && in_ready;

  srpc_rx u_rx (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  srpc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign status          = out_data.status;
  assign servo_flags     = out_data.servo_flags;
  assign first_data_byte = out_data.first_data_byte;
  assign angle           = out_data.angle;
  assign move_time       = out_data.move_time;
  assign speed           = out_data.speed;
  assign load            = out_data.load;
  assign temperature     = out_data.temperature;

endmodule

[src/srpc_checker.sv]
// ----------------------------------------------------------------------------
// srpc_checker
// Port-level checks for the servo reply packet checker.
// ----------------------------------------------------------------------------
module srpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  servo_flags,
  input logic [7:0]  first_data_byte,
  input logic [15:0] angle,
  input logic [15:0] move_time,
  input logic [15:0] speed,
  input logic [15:0] load,
  input logic [15:0] temperature
);
  import srpc_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(angle))
    else $error("stalled result changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TIMEOUT || status == ST_CSUM) |->
      servo_flags == 8'd0 && first_data_byte == 8'd0 && angle == 16'd0 &&
      move_time == 16'd0 && speed == 16'd0 && load == 16'd0 &&
      temperature == 16'd0)
    else $error("error result carries field data");

  a_flags_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_OK) == (servo_flags == 8'd0 &&
      status != ST_TIMEOUT && status != ST_CSUM)))
    else $error("status disagrees with flag byte");

  a_byte_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_TIMEOUT && status != ST_CSUM |->
      first_data_byte == angle[7:0])
    else $error("first data byte differs from angle low byte");

endmodule

bind servo_reply_packet_checker srpc_checker u_srpc_checker (.*);

[verif/tb_servo_reply_packet_checker.sv]
// ----------------------------------------------------------------------------
// tb_servo_reply_packet_checker
// Feeds servo reply packets word by word into the checker under random input
// gaps and output stalls. Every report is compared field by field against an
// untimed model of the deframer kept in the bench.
// ----------------------------------------------------------------------------
module tb_servo_reply_packet_checker;
  import srpc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT       = 600000;
  localparam int RANDOM_WORDS      = 620;
  localparam int SUM_START         = 2;
  localparam int FIRST_DATA_OFFSET = DATA_BASE + 1;
  localparam int LAST_DATA_OFFSET  = DATA_BASE + CAP_SLOTS - 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = 2'd0;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  status;
  logic [7:0]  servo_flags;
  logic [7:0]  first_data_byte;
  logic [15:0] angle;
  logic [15:0] move_time;
  logic [15:0] speed;
  logic [15:0] load;
  logic [15:0] temperature;

  // deframer model state
  logic [5:0]                   cfg_reply_length = 6'd26;
  logic [15:0]                  cfg_timeout_limit = 16'd400;
  bit                           rx_armed = 1'b0;
  int                           rx_count = 0;
  logic [7:0]                   rx_xor = 8'd0;
  logic [7:0]                   rx_capture [CAP_SLOTS] = '{default: 8'd0};
  logic [TICK_COUNTER_BITS-1:0] rx_ticks = '0;

  result_t pending_reports [$];
  int      errors = 0;
  int      words_counted = 0;
  int      reports_checked = 0;
  int      status_seen [4] = '{default: 0};
  int      cycles = 0;
  int      gap_pct = 20;
  int      stall_pct = 20;
  int      stall_left = 0;
  bit      calm = 1'b0;

  servo_reply_packet_checker dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .servo_flags(servo_flags), .first_data_byte(first_data_byte),
    .angle(angle), .move_time(move_time), .speed(speed), .load(load),
    .temperature(temperature)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
      $display("[servo_reply_packet_checker] ERROR");
      $finish;
    end
  end

  // output stall bursts
  always @(posedge clk) begin
    if (rst || calm || stall_pct == 0) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int frame_length();
    int n;
    n = cfg_reply_length;
    if (n < MIN_REPLY_LENGTH) n = MIN_REPLY_LENGTH;
    if (n > MAX_REPLY_LENGTH) n = MAX_REPLY_LENGTH;
    return n;
  endfunction

  function automatic logic [7:0] byte_at(input int k);
    if (k >= frame_length()) return 8'd0;
    if (k == FLAG_OFFSET) return rx_capture[0];
    if (k >= FIRST_DATA_OFFSET && k <= LAST_DATA_OFFSET) return rx_capture[k - DATA_BASE];
    return 8'd0;
  endfunction

  function automatic logic [15:0] field_at(input int k);
    return {byte_at(k + 1), byte_at(k)};
  endfunction

  // returns 1 when the word completes a report
  function automatic bit deframe_word(input logic [1:0] w_op, input logic [7:0] w_byte,
                                      output result_t rep);
    rep = '0;
    if (w_op == OP_START) begin
      rx_armed = 1'b1;
      rx_count = 0;
      rx_xor = 8'd0;
      rx_ticks = '0;
      for (int s = 0; s < CAP_SLOTS; s++) rx_capture[s] = 8'd0;
      return 1'b0;
    end
    if (!rx_armed) return 1'b0;
    if (w_op == OP_TICK) begin
      if (rx_ticks != '1) rx_ticks++;
      if (rx_ticks > cfg_timeout_limit) begin
        rep.status = ST_TIMEOUT;
        rx_armed = 1'b0;
        return 1'b1;
      end
      return 1'b0;
    end
    if (w_op != OP_BYTE) return 1'b0;
    if (rx_count == FLAG_OFFSET) rx_capture[0] = w_byte;
    else if (rx_count >= FIRST_DATA_OFFSET && rx_count <= LAST_DATA_OFFSET)
      rx_capture[rx_count - DATA_BASE] = w_byte;
    if (rx_count >= SUM_START) rx_xor ^= w_byte;
    if (rx_count < 255) rx_count++;
    if (rx_count < frame_length()) return 1'b0;
    rx_armed = 1'b0;
    if (rx_xor != 8'd0) begin
      rep.status = ST_CSUM;
      return 1'b1;
    end
    rep.servo_flags = byte_at(FLAG_OFFSET);
    rep.status = (rep.servo_flags != 8'd0) ? ST_FLAGS : ST_OK;
    rep.first_data_byte = byte_at(FIRST_DATA_OFFSET);
    rep.angle = field_at(FIRST_DATA_OFFSET);
    rep.move_time = field_at(FIRST_DATA_OFFSET + 2);
    rep.speed = field_at(FIRST_DATA_OFFSET + 4);
    rep.load = field_at(FIRST_DATA_OFFSET + 6);
    rep.temperature = field_at(FIRST_DATA_OFFSET + 8);
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, status expected none actual %h",
                 $time, status);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        status_seen[status]++;
        check_field("status", 16'(want.status), 16'(status));
        check_field("servo_flags", 16'(want.servo_flags), 16'(servo_flags));
        check_field("first_data_byte", 16'(want.first_data_byte), 16'(first_data_byte));
        check_field("angle", want.angle, angle);
        check_field("move_time", want.move_time, move_time);
        check_field("speed", want.speed, speed);
        check_field("load", want.load, load);
        check_field("temperature", want.temperature, temperature);
      end
    end
  end

  task automatic send_word(input logic [1:0] w_op, input logic [7:0] w_byte);
    result_t rep;
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= w_op;
    rx_byte <= w_byte;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (w_op == OP_START || (rx_armed && (w_op == OP_BYTE || w_op == OP_TICK)))
      words_counted++;
    if (deframe_word(w_op, w_byte, rep)) pending_reports.push_back(rep);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REPLY_LENGTH) cfg_reply_length = value[5:0];
    else cfg_timeout_limit = value;
    @(posedge clk);
  endtask

  // fill below zero gives random bytes; cut above zero stops after that many bytes
  task automatic send_packet(input int len, input int fill, input bit clear_flags,
                             input bit bad_sum, input int tick_pct, input int cut);
    logic [7:0] pkt [MAX_REPLY_LENGTH];
    logic [7:0] sum;
    int stop;
    sum = 8'd0;
    stop = (cut > 0) ? cut : len;
    for (int k = 0; k < len; k++) pkt[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (clear_flags) pkt[FLAG_OFFSET] = 8'd0;
    for (int k = SUM_START; k < len - 1; k++) sum ^= pkt[k];
    pkt[len - 1] = bad_sum ? (sum ^ (8'd1 << $urandom_range(0, 7))) : sum;
    send_word(OP_START, 8'($urandom));
    for (int k = 0; k < stop; k++) begin
      if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct)
        send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, pkt[k]);
    end
  endtask

  task automatic test_reset_config();
    send_packet(26, 255, 1'b0, 1'b0, 10, 0);
    send_packet(26, 0, 1'b1, 1'b0, 0, 0);
    wait_idle();
  endtask

  task automatic test_ignored_words();
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_TICK, 8'h00);
    send_word(OP_UNUSED, 8'hA5);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_START, 8'h5A);
    send_word(OP_UNUSED, 8'hFF);
    wait_idle();
  endtask

  task automatic test_short_reply();
    write_reg(REG_REPLY_LENGTH, 16'hFFC0);
    send_packet(frame_length(), -1, 1'b0, 1'b0, 0, 0);
    write_reg(REG_REPLY_LENGTH, 16'd12);
    send_packet(frame_length(), -1, 1'b0, 1'b0, 0, 0);
    write_reg(REG_REPLY_LENGTH, 16'h003F);
    send_packet(frame_length(), -1, 1'b0, 1'b0, 0, 0);
    wait_idle();
  endtask

  task automatic test_checksum_error();
    write_reg(REG_REPLY_LENGTH, 16'd17);
    send_packet(frame_length(), 255, 1'b0, 1'b1, 0, 0);
    wait_idle();
  endtask

  task automatic test_timeout();
    write_reg(REG_TIMEOUT_LIMIT, 16'd0);
    send_word(OP_START, 8'h00);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_TICK, 8'h00);
    send_word(OP_BYTE, 8'h12);
    wait_idle();
    write_reg(REG_TIMEOUT_LIMIT, 16'd3);
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    repeat (4) send_word(OP_TICK, 8'($urandom));
    wait_idle();
  endtask

  task automatic test_restart();
    write_reg(REG_TIMEOUT_LIMIT, 16'd1000);
    send_packet(frame_length(), -1, 1'b0, 1'b0, 0, 5);
    send_packet(frame_length(), -1, 1'b1, 1'b0, 0, 0);
    wait_idle();
  endtask

  task automatic test_length_change();
    logic [7:0] b;
    logic [7:0] sum;
    sum = 8'd0;
    write_reg(REG_REPLY_LENGTH, 16'd20);
    send_word(OP_START, 8'h00);
    for (int k = 0; k < 12; k++) begin
      b = 8'($urandom);
      if (k >= SUM_START) sum ^= b;
      send_word(OP_BYTE, b);
    end
    wait_idle();
    // shorter length now lies below the count, so the next byte completes
    write_reg(REG_REPLY_LENGTH, 16'd9);
    send_word(OP_BYTE, sum);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int first_words;
    int tick_pct;
    int kind;
    logic [5:0] len_sel;
    logic [15:0] limit;
    first_words = words_counted;
    while (words_counted - first_words < RANDOM_WORDS) begin
      wait_idle();
      case ($urandom_range(0, 5))
        0: len_sel = 6'd0;
        1: len_sel = 6'd63;
        2: len_sel = 6'd9;
        3: len_sel = 6'd32;
        4: len_sel = 6'd26;
        default: len_sel = 6'($urandom_range(0, 63));
      endcase
      write_reg(REG_REPLY_LENGTH, {10'($urandom), len_sel});
      case ($urandom_range(0, 3))
        0: limit = 16'($urandom_range(0, 12));
        1: limit = 16'hFFFF;
        default: limit = 16'($urandom_range(40, 3000));
      endcase
      write_reg(REG_TIMEOUT_LIMIT, limit);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 35;
      endcase
      tick_pct = $urandom_range(0, 25);
      repeat ($urandom_range(2, 6)) begin
        kind = $urandom_range(0, 19);
        if (kind < 13)
          send_packet(frame_length(), -1, $urandom_range(0, 2) == 0, 1'b0, tick_pct, 0);
        else if (kind < 15)
          send_packet(frame_length(), -1, 1'b0, 1'b1, tick_pct, 0);
        else if (kind < 17)
          send_packet(frame_length(), -1, 1'b0, 1'b0, tick_pct,
                      $urandom_range(1, frame_length() - 1));
        else
          repeat ($urandom_range(3, 10)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
    wait_idle();
  endtask

  task automatic test_final_stretch();
    calm = 1'b1;
    write_reg(REG_REPLY_LENGTH, 16'($urandom_range(9, 32)));
    write_reg(REG_TIMEOUT_LIMIT, 16'd500);
    repeat (4) send_packet(frame_length(), -1, $urandom_range(0, 1) == 0, 1'b0, 5, 0);
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_config();
    test_ignored_words();
    test_short_reply();
    test_checksum_error();
    test_timeout();
    test_restart();
    test_length_change();
    test_random_traffic();
    test_final_stretch();
    $display("deframer saw %0d effective words, %0d reports checked", words_counted,
             reports_checked);
    $display("reports by status: ok %0d, timeout %0d, checksum %0d, flags %0d",
             status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_CSUM],
             status_seen[ST_FLAGS]);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("[servo_reply_packet_checker] OK");
    end else begin
      $display("[servo_reply_packet_checker] ERROR");
    end
    $finish;
  end

endmodule
